/* sv/fsa_pkg.sv */
// Shared types and codes of the frame stack allocator.
package fsa_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd1;

    localparam logic [31:0] CAPACITY_RESET = 32'd4096;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NO_FRAME = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] request_size;
        logic [3:0]  align_log2;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] address;
        logic [31:0] used_bytes;
        logic [6:0]  frame_depth;
    } rsp_t;

endpackage

/* sv/frame_stack_allocator.sv */
// Top level of the frame stack allocator: request register, operation logic, response register.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------------
//  req     | req_valid/req_ready  | req_t: opcode, request_size, align_log2
//  rsp     | rsp_valid/rsp_ready  | rsp_t: status, address, used_bytes, frame_depth
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (base address, capacity)
//
// A request is held in the request register and its response in the response
// register; one request is taken every cycle while the response is not stalled.
// The top frame's byte count lives in a register and the frame below it in a
// prefetch register fed by the frame memory's registered read, so back-to-back
// pops never wait. Reset clears usage and frame depth; capacity returns to 4096.
// A stalled response holds the request register, which then lowers req_ready.
module frame_stack_allocator
    import fsa_pkg::*;
#(
    parameter int unsigned MAX_FRAMES   = 64,
    parameter int unsigned HEADER_BYTES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int unsigned DEPTH_W = $clog2(MAX_FRAMES + 1);
    localparam int unsigned IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned REM_W   = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

    logic               in_valid_reg;
    req_t               in_req_reg;
    logic               out_valid_reg;
    rsp_t               out_rsp_reg;

    logic [31:0]        base_reg;
    logic [31:0]        cap_reg;
    logic [31:0]        used_reg;
    logic [31:0]        top_addr_reg;
    logic [DEPTH_W-1:0] open_reg;
    logic [31:0]        top_bytes_reg;
    logic [31:0]        below_reg;
    logic [31:0]        frame_mem [MAX_FRAMES];

    logic               fire;
    logic [REM_W-1:0]   hdr_rem;
    logic [31:0]        push_pad;
    logic [32:0]        push_need;
    logic [15:0]        align_mask;
    logic [15:0]        alloc_pad;
    logic [32:0]        alloc_total;
    logic [33:0]        alloc_need;
    logic [32:0]        pop_rel;
    logic               pop_clears;
    logic               has_frame;
    logic               store_full;

    logic [1:0]         status_next;
    logic [31:0]        address_next;
    logic [31:0]        used_next;
    logic [31:0]        top_addr_next;
    logic [DEPTH_W-1:0] open_next;
    logic [31:0]        top_bytes_next;
    logic               push_ok;
    logic               pop_ok;
    logic [31:0]        depth_wide;
    rsp_t               rsp_next;

    assign fire      = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || fire;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;
    assign cfg_ready = 1'b1;

    fsa_hdr_rem #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_hdr_rem (
        .value (top_addr_reg),
        .rem   (hdr_rem)
    );

    always_comb
    begin
        has_frame   = open_reg != '0;
        store_full  = 32'(open_reg) >= MAX_FRAMES;
        push_pad    = (hdr_rem == '0) ? 32'd0 : 32'(HEADER_BYTES) - 32'(hdr_rem);
        push_need   = 33'(used_reg) + 33'(HEADER_BYTES) + 33'(push_pad);
        align_mask  = ~(16'hFFFF << in_req_reg.align_log2);
        alloc_pad   = (16'd0 - top_addr_reg[15:0]) & align_mask;
        alloc_total = 33'(in_req_reg.request_size) + 33'(alloc_pad);
        alloc_need  = 34'(used_reg) + 34'(alloc_total);
        pop_rel     = 33'(top_bytes_reg) + 33'(HEADER_BYTES);
        pop_clears  = pop_rel >= 33'(used_reg);
    end

    always_comb
    begin
        status_next    = ST_OK;
        address_next   = 32'd0;
        used_next      = used_reg;
        top_addr_next  = top_addr_reg;
        open_next      = open_reg;
        top_bytes_next = top_bytes_reg;
        push_ok        = 1'b0;
        pop_ok         = 1'b0;
        unique case (in_req_reg.opcode)
            OP_PUSH:
            begin
                if (store_full)
                begin
                    status_next = ST_FULL;
                end
                else if (push_need > 33'(cap_reg))
                begin
                    status_next = ST_NO_SPACE;
                end
                else
                begin
                    push_ok        = 1'b1;
                    used_next      = push_need[31:0];
                    top_addr_next  = top_addr_reg + push_pad + 32'(HEADER_BYTES);
                    open_next      = open_reg + DEPTH_W'(1);
                    top_bytes_next = push_pad;
                end
            end
            OP_POP:
            begin
                if (!has_frame)
                begin
                    status_next = ST_NO_FRAME;
                end
                else
                begin
                    pop_ok         = 1'b1;
                    open_next      = open_reg - DEPTH_W'(1);
                    top_bytes_next = below_reg;
                    used_next      = pop_clears ? 32'd0 : used_reg - pop_rel[31:0];
                    top_addr_next  = pop_clears ? base_reg : top_addr_reg - pop_rel[31:0];
                end
            end
            OP_ALLOC:
            begin
                if (!has_frame)
                begin
                    status_next = ST_NO_FRAME;
                end
                else if (alloc_need > 34'(cap_reg))
                begin
                    status_next = ST_NO_SPACE;
                end
                else
                begin
                    used_next      = alloc_need[31:0];
                    top_addr_next  = top_addr_reg + alloc_total[31:0];
                    top_bytes_next = top_bytes_reg + alloc_total[31:0];
                    address_next   = top_addr_reg + 32'(alloc_pad);
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        depth_wide           = 32'(open_next);
        rsp_next.status      = status_next;
        rsp_next.address     = address_next;
        rsp_next.used_bytes  = used_next;
        rsp_next.frame_depth = depth_wide[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= 32'd0;
            cap_reg       <= CAPACITY_RESET;
            used_reg      <= 32'd0;
            top_addr_reg  <= 32'd0;
            open_reg      <= '0;
        end
        else
        begin
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                used_reg      <= used_next;
                top_addr_reg  <= top_addr_next;
                open_reg      <= open_next;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_BASE_ADDRESS)
                begin
                    base_reg     <= cfg_data;
                    top_addr_reg <= cfg_data + used_reg;
                end
                else if (cfg_index == CFG_CAPACITY)
                begin
                    cap_reg <= cfg_data;
                end
            end
        end
    end

    // Payload registers and the frame store carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_req_reg <= req;
        end
        if (fire)
        begin
            out_rsp_reg   <= rsp_next;
            top_bytes_reg <= top_bytes_next;
        end
    end

    // The store holds every open frame except the top one. A push spills the old
    // top, which also becomes the new frame below; a pop refills the frame below
    // from the store.
    always_ff @(posedge clk)
    begin
        if (fire && push_ok && open_reg != '0)
        begin
            frame_mem[IDX_W'(open_reg - DEPTH_W'(1))] <= top_bytes_reg;
            below_reg                                 <= top_bytes_reg;
        end
        else if (fire && pop_ok && 32'(open_reg) >= 32'd3)
        begin
            below_reg <= frame_mem[IDX_W'(open_reg - DEPTH_W'(3))];
        end
    end

endmodule

/* sv/fsa_hdr_rem.sv */
// Remainder of a 32-bit address by the frame header size, built from constant tables.
module fsa_hdr_rem
    import fsa_pkg::*;
#(
    parameter int unsigned HEADER_BYTES = 16
)
(
    input  logic [31:0]                                               value,
    output logic [((HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1)-1:0] rem
);

    localparam int unsigned REM_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int unsigned SUM_W = REM_W + 2;

    // Each byte contributes (byte * 2^(8*i)) mod HEADER_BYTES; the four partial
    // remainders sum to less than 4 * HEADER_BYTES and are folded once more.
    wire [REM_W-1:0] byte_tbl [4][256];
    wire [REM_W-1:0] fold_tbl [2**SUM_W];

    for (genvar gi = 0; gi < 4; gi++) begin : g_byte
        localparam int unsigned WEIGHT = (32'd1 << (8 * gi)) % HEADER_BYTES;
        for (genvar gb = 0; gb < 256; gb++) begin : g_entry
            localparam int unsigned ENTRY = (gb * WEIGHT) % HEADER_BYTES;
            assign byte_tbl[gi][gb] = REM_W'(ENTRY);
        end
    end

    for (genvar gv = 0; gv < 2**SUM_W; gv++) begin : g_fold
        localparam int unsigned FOLD = gv % HEADER_BYTES;
        assign fold_tbl[gv] = REM_W'(FOLD);
    end

    logic [SUM_W-1:0] partial_sum;

    always_comb
    begin
        partial_sum = SUM_W'(byte_tbl[0][value[7:0]])
                    + SUM_W'(byte_tbl[1][value[15:8]])
                    + SUM_W'(byte_tbl[2][value[23:16]])
                    + SUM_W'(byte_tbl[3][value[31:24]]);
        rem = fold_tbl[partial_sum];
    end

endmodule

/* sv/fsa_checker.sv */
// Port-level checker of the frame stack allocator and its bind statement.
module fsa_checker
    import fsa_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // A stalled response must not change.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // Requests are refused only while a response is held back.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request refused without a stalled response");

    // A response out of an empty output comes from a request taken into the request register just before it.
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !$past(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response appeared without a matching request");

    // Consecutive responses differ in frame depth by at most one.
    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rsp_valid && rsp_ready) && rsp_valid |->
            7'(rsp.frame_depth - $past(rsp.frame_depth)) == 7'd0 ||
            7'(rsp.frame_depth - $past(rsp.frame_depth)) == 7'd1 ||
            7'(rsp.frame_depth - $past(rsp.frame_depth)) == 7'd127)
        else $error("frame depth jumped between responses");

endmodule

bind frame_stack_allocator fsa_checker u_fsa_checker (.*);
